[rtl/core/brfs_pkg.sv]
// ----------------------------------------------------------------------------
// brfs_pkg - shared types and constants of the byte ring fifo with search
// operation codes, controller states, command/status bundles, field widths
// ----------------------------------------------------------------------------
package brfs_pkg;

   // field widths
   localparam int FUNC_W = 3;
   localparam int BYTE_W = 8;
   localparam int CNT_W  = 10;

   // defaults and fixed constants
   localparam int DEPTH_DEF   = 1024;
   localparam int MAX_READ    = 64;
   localparam int PAIR_LEN    = 2;
   localparam int WRITE_SLACK = 2;

   typedef enum logic [FUNC_W-1:0] {
      OP_WRITE = 3'd0,
      OP_READ  = 3'd1,
      OP_POP   = 3'd2,
      OP_SKIP  = 3'd3,
      OP_PEEK  = 3'd4,
      OP_FIND  = 3'd5,
      OP_PAIR  = 3'd6,
      OP_CLEAR = 3'd7
   } fifo_op_type;

   typedef enum logic [2:0] {
      ST_INIT = 3'd0,
      ST_IDLE = 3'd1,
      ST_EXEC = 3'd2,
      ST_WALK = 3'd3,
      ST_PEEK = 3'd4,
      ST_WIPE = 3'd5
   } state_type;

   typedef struct packed {
      logic take;
      logic exec;
      logic walk;
      logic wipe;
      logic wipe_rsp;
      logic peek_rsp;
   } cmd_type;

   typedef struct packed {
      fifo_op_type op;
      logic        read_go;
      logic        peek_go;
      logic        skip_more;
      logic        walk_end;
      logic        wipe_last;
   } stat_type;

endpackage

[rtl/core/brfs_ctrl.sv]
// ----------------------------------------------------------------------------
// brfs_ctrl - sequencer of the byte ring fifo
// steps through init sweep, idle, execute, store walk, peek and clear sweep
// ----------------------------------------------------------------------------
module brfs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  brfs_pkg::stat_type stat,
   output brfs_pkg::cmd_type  cmd,
   output logic               busy
);

   brfs_pkg::state_type state_ff;
   brfs_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= brfs_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         brfs_pkg::ST_INIT: begin
            if (stat.wipe_last) state_in = brfs_pkg::ST_IDLE;
         end
         brfs_pkg::ST_IDLE: begin
            if (start) state_in = brfs_pkg::ST_EXEC;
         end
         brfs_pkg::ST_EXEC: begin
            case (stat.op)
               brfs_pkg::OP_READ:
                  state_in = stat.read_go ? brfs_pkg::ST_WALK : brfs_pkg::ST_IDLE;
               brfs_pkg::OP_PEEK:
                  state_in = stat.peek_go ? brfs_pkg::ST_PEEK : brfs_pkg::ST_IDLE;
               brfs_pkg::OP_FIND, brfs_pkg::OP_PAIR:
                  state_in = brfs_pkg::ST_WALK;
               brfs_pkg::OP_SKIP:
                  state_in = stat.skip_more ? brfs_pkg::ST_EXEC : brfs_pkg::ST_IDLE;
               brfs_pkg::OP_CLEAR:
                  state_in = brfs_pkg::ST_WIPE;
               default:
                  state_in = brfs_pkg::ST_IDLE;
            endcase
         end
         brfs_pkg::ST_WALK: begin
            if (stat.walk_end) state_in = brfs_pkg::ST_IDLE;
         end
         brfs_pkg::ST_PEEK: begin
            state_in = brfs_pkg::ST_IDLE;
         end
         brfs_pkg::ST_WIPE: begin
            if (stat.wipe_last) state_in = brfs_pkg::ST_IDLE;
         end
         default: begin
            state_in = brfs_pkg::ST_INIT;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         brfs_pkg::ST_INIT: begin
            cmd.wipe = 1'b1;
         end
         brfs_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.take = start;
         end
         brfs_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
         end
         brfs_pkg::ST_WALK: begin
            cmd.walk = 1'b1;
         end
         brfs_pkg::ST_PEEK: begin
            cmd.peek_rsp = 1'b1;
         end
         brfs_pkg::ST_WIPE: begin
            cmd.wipe     = 1'b1;
            cmd.wipe_rsp = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

[rtl/core/brfs_datapath.sv]
// ----------------------------------------------------------------------------
// brfs_datapath - ring store, pointers, walk pipeline and result registers
// store with one write port and one registered read port, one byte visited per cycle
// ----------------------------------------------------------------------------
module brfs_datapath #(
   parameter int DEPTH = brfs_pkg::DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  brfs_pkg::cmd_type            cmd,
   output brfs_pkg::stat_type           stat,
   input  logic [brfs_pkg::FUNC_W-1:0]  req_func,
   input  logic [brfs_pkg::BYTE_W-1:0]  req_data_byte,
   input  logic [brfs_pkg::BYTE_W-1:0]  req_second_byte,
   input  logic [brfs_pkg::CNT_W-1:0]   req_count,
   input  logic [brfs_pkg::CNT_W-1:0]   req_position,
   output logic                         rsp_valid,
   output logic                         rsp_ok,
   output logic [brfs_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic [brfs_pkg::CNT_W-1:0]   rsp_found_pos,
   output logic [brfs_pkg::CNT_W-1:0]   rsp_used_count,
   output logic [brfs_pkg::CNT_W-1:0]   rsp_free_count,
   output logic                         rsp_last
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CMP_W = (IDX_W + 1 > brfs_pkg::CNT_W + 1) ? IDX_W + 1 : brfs_pkg::CNT_W + 1;
   localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W + 1)'(DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CMP_W-1:0] DEPTH_C  = CMP_W'(DEPTH);
   localparam logic [CMP_W-1:0] MAXRD_C  = CMP_W'(brfs_pkg::MAX_READ);
   localparam logic [IDX_W:0]   SLACK_X  = (IDX_W + 1)'(brfs_pkg::WRITE_SLACK);
   localparam logic [IDX_W-1:0] PAIR_OFF = IDX_W'(brfs_pkg::PAIR_LEN - 1);
   localparam logic [brfs_pkg::CNT_W-1:0] DEPTH_CNT = brfs_pkg::CNT_W'(DEPTH);

   // a + b mod DEPTH, both operands below DEPTH
   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
      logic [IDX_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= DEPTH_X) s = s - DEPTH_X;
      return s[IDX_W-1:0];
   endfunction

   // a - b mod DEPTH
   function automatic logic [IDX_W-1:0] ring_sub(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
      logic [IDX_W:0] s;
      if (a >= b) s = {1'b0, a} - {1'b0, b};
      else        s = {1'b0, a} + DEPTH_X - {1'b0, b};
      return s[IDX_W-1:0];
   endfunction

   logic [brfs_pkg::BYTE_W-1:0] mem [0:DEPTH-1];

   // latched request
   brfs_pkg::fifo_op_type       op_ff;
   logic [brfs_pkg::BYTE_W-1:0] b1_ff, b2_ff;
   logic [brfs_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [brfs_pkg::CNT_W-1:0]  pos_ff;

   // ring state
   logic [IDX_W-1:0] rptr_ff, rptr_in;
   logic [IDX_W-1:0] wptr_ff, wptr_in;
   logic [IDX_W-1:0] used_ff, used_in;
   logic [IDX_W-1:0] clr_addr_ff, clr_addr_in;

   // walk pipeline
   logic [IDX_W-1:0]            walk_addr_ff, walk_addr_in;
   logic [IDX_W-1:0]            issue_off_ff, issue_off_in;
   logic [IDX_W-1:0]            limit_ff, limit_in;
   logic                        cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]            cmp_off_ff;
   logic [brfs_pkg::BYTE_W-1:0] prev_byte_ff;
   logic [brfs_pkg::BYTE_W-1:0] rd_data_ff;

   // result registers
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_ok_ff, rsp_ok_in;
   logic [brfs_pkg::BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic [IDX_W-1:0]            rsp_pos_ff, rsp_pos_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic [IDX_W-1:0]            free_cnt;
   logic                        free_ok, read_go, pop_ok, peek_go, skip_more;
   logic [CMP_W-1:0]            cnt_c, used_c, pos_c;
   logic [IDX_W-1:0]            cnt_idx, pos_idx;
   logic                        issuing, exhausted, hit, rd_last, walk_end;
   logic [IDX_W-1:0]            rd_addr, wr_addr;
   logic [brfs_pkg::BYTE_W-1:0] wr_data;
   logic                        wr_en;

   assign free_cnt  = LAST_IDX - used_ff;
   assign free_ok   = {1'b0, free_cnt} >= SLACK_X;
   assign cnt_c     = CMP_W'(cnt_ff);
   assign used_c    = CMP_W'(used_ff);
   assign pos_c     = CMP_W'(pos_ff);
   assign cnt_idx   = IDX_W'(cnt_ff);
   assign pos_idx   = IDX_W'(pos_ff);
   assign read_go   = (cnt_ff != '0) && (cnt_c <= MAXRD_C) && (cnt_c <= used_c);
   assign pop_ok    = cnt_c <= used_c;
   assign peek_go   = pos_c < used_c;
   assign skip_more = cnt_c >= DEPTH_C;

   assign issuing   = issue_off_ff < limit_ff;
   assign exhausted = !cmp_valid_ff && !issuing;
   assign rd_last   = cmp_off_ff == (limit_ff - IDX_W'(1));

   always_comb begin
      case (op_ff)
         brfs_pkg::OP_FIND: hit = rd_data_ff == b1_ff;
         brfs_pkg::OP_PAIR: hit = (cmp_off_ff >= PAIR_OFF) && (prev_byte_ff == b1_ff)
                                  && (rd_data_ff == b2_ff);
         default:           hit = 1'b0;
      endcase
   end

   assign walk_end = exhausted ||
                     (cmp_valid_ff && ((op_ff == brfs_pkg::OP_READ) ? rd_last : hit));

   assign stat.op        = op_ff;
   assign stat.read_go   = read_go;
   assign stat.peek_go   = peek_go;
   assign stat.skip_more = skip_more;
   assign stat.walk_end  = walk_end;
   assign stat.wipe_last = clr_addr_ff == LAST_IDX;

   // store port selection
   assign rd_addr = cmd.exec ? ring_add(rptr_ff, pos_idx) : walk_addr_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = wptr_ff;
      wr_data = b1_ff;
      if (cmd.wipe) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else if (cmd.exec && (op_ff == brfs_pkg::OP_WRITE) && free_ok) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   // pointer and walk updates
   always_comb begin
      rptr_in      = rptr_ff;
      wptr_in      = wptr_ff;
      cnt_in       = cnt_ff;
      clr_addr_in  = clr_addr_ff;
      walk_addr_in = walk_addr_ff;
      issue_off_in = issue_off_ff;
      limit_in     = limit_ff;
      cmp_valid_in = 1'b0;

      if (cmd.take) cnt_in = req_count;

      if (cmd.wipe) clr_addr_in = (clr_addr_ff == LAST_IDX) ? '0 : clr_addr_ff + IDX_W'(1);

      if (cmd.exec) begin
         case (op_ff)
            brfs_pkg::OP_WRITE: begin
               if (free_ok) wptr_in = ring_add(wptr_ff, IDX_W'(1));
            end
            brfs_pkg::OP_READ: begin
               if (read_go) rptr_in = ring_add(rptr_ff, cnt_idx);
               walk_addr_in = rptr_ff;
               issue_off_in = '0;
               limit_in     = cnt_idx;
            end
            brfs_pkg::OP_POP: begin
               if (pop_ok) rptr_in = ring_add(rptr_ff, cnt_idx);
            end
            brfs_pkg::OP_SKIP: begin
               // counts at or above the ring size fold down one lap a cycle
               if (skip_more) cnt_in  = cnt_ff - DEPTH_CNT;
               else           rptr_in = ring_add(rptr_ff, cnt_idx);
            end
            brfs_pkg::OP_FIND, brfs_pkg::OP_PAIR: begin
               walk_addr_in = rptr_ff;
               issue_off_in = '0;
               limit_in     = used_ff;
            end
            brfs_pkg::OP_CLEAR: begin
               rptr_in     = '0;
               wptr_in     = '0;
               clr_addr_in = '0;
            end
            default: begin
               rptr_in = rptr_ff;
            end
         endcase
      end

      if (cmd.walk && issuing) begin
         walk_addr_in = ring_add(walk_addr_ff, IDX_W'(1));
         issue_off_in = issue_off_ff + IDX_W'(1);
         cmp_valid_in = 1'b1;
      end
   end

   assign used_in = ring_sub(wptr_in, rptr_in);

   // result selection
   always_comb begin
      rsp_valid_in = 1'b0;
      rsp_ok_in    = 1'b0;
      rsp_byte_in  = '0;
      rsp_pos_in   = '0;
      rsp_last_in  = 1'b1;

      if (cmd.exec) begin
         case (op_ff)
            brfs_pkg::OP_WRITE: begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = free_ok;
            end
            brfs_pkg::OP_READ: begin
               rsp_valid_in = !read_go;
            end
            brfs_pkg::OP_POP: begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = pop_ok;
            end
            brfs_pkg::OP_SKIP: begin
               rsp_valid_in = !skip_more;
               rsp_ok_in    = 1'b1;
            end
            brfs_pkg::OP_PEEK: begin
               rsp_valid_in = !peek_go;
            end
            default: begin
               rsp_valid_in = 1'b0;
            end
         endcase
      end

      if (cmd.walk) begin
         if (cmp_valid_ff && (op_ff == brfs_pkg::OP_READ)) begin
            rsp_valid_in = 1'b1;
            rsp_ok_in    = 1'b1;
            rsp_byte_in  = rd_data_ff;
            rsp_last_in  = rd_last;
         end else if (cmp_valid_ff && hit) begin
            rsp_valid_in = 1'b1;
            rsp_ok_in    = 1'b1;
            rsp_pos_in   = cmp_off_ff;
         end else if (exhausted) begin
            rsp_valid_in = 1'b1;
         end
      end

      if (cmd.peek_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = 1'b1;
         rsp_byte_in  = rd_data_ff;
      end

      if (cmd.wipe_rsp && stat.wipe_last) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rptr_ff      <= '0;
         wptr_ff      <= '0;
         used_ff      <= '0;
         clr_addr_ff  <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rptr_ff      <= rptr_in;
         wptr_ff      <= wptr_in;
         used_ff      <= used_in;
         clr_addr_ff  <= clr_addr_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         op_ff  <= brfs_pkg::fifo_op_type'(req_func);
         b1_ff  <= req_data_byte;
         b2_ff  <= req_second_byte;
         pos_ff <= req_position;
      end
      cnt_ff       <= cnt_in;
      walk_addr_ff <= walk_addr_in;
      issue_off_ff <= issue_off_in;
      limit_ff     <= limit_in;
      cmp_off_ff   <= issue_off_ff;
      if (cmp_valid_ff) prev_byte_ff <= rd_data_ff;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_found_pos  = brfs_pkg::CNT_W'(rsp_pos_ff);
   assign rsp_used_count = brfs_pkg::CNT_W'(used_ff);
   assign rsp_free_count = brfs_pkg::CNT_W'(free_cnt);
   assign rsp_last       = rsp_last_ff;

endmodule

[rtl/core/byte_ring_fifo_with_search_top.sv]
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_search_top - byte ring fifo with search operations
// write, read, pop, skip, peek, byte and pair search, clear over a byte ring
// ----------------------------------------------------------------------------
// usage
//  - a request is taken at a clock edge with start high and busy low; the
//    req_ ports carry the operation code and its operands
//  - every request gives one result, except a granted read of n bytes which
//    gives n results on consecutive cycles; rsp_last marks the final one
//  - each result shows on the rsp_ ports for one cycle with rsp_valid high;
//    the receiver cannot hold results off, so no stall path exists
//  - write, pop, skip and any refusal are settled in the execute state and
//    their result is registered from that state
//  - peek answers from the peek state; a read streams from the walk state
//  - searches walk the store one byte per cycle through the store read
//    port and stop at the first match
//  - a skip whose count reaches the ring size re-executes once per lap
//  - clear rewrites every cell with zero in the clear sweep
//  - after reset the store is swept to zero with busy high
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_search_top #(
   parameter int DEPTH = brfs_pkg::DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [brfs_pkg::FUNC_W-1:0]  req_func,
   input  logic [brfs_pkg::BYTE_W-1:0]  req_data_byte,
   input  logic [brfs_pkg::BYTE_W-1:0]  req_second_byte,
   input  logic [brfs_pkg::CNT_W-1:0]   req_count,
   input  logic [brfs_pkg::CNT_W-1:0]   req_position,
   output logic                         rsp_valid,
   output logic                         rsp_ok,
   output logic [brfs_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic [brfs_pkg::CNT_W-1:0]   rsp_found_pos,
   output logic [brfs_pkg::CNT_W-1:0]   rsp_used_count,
   output logic [brfs_pkg::CNT_W-1:0]   rsp_free_count,
   output logic                         rsp_last
);

   // command and status between sequencer and datapath
   brfs_pkg::cmd_type  cmd;
   brfs_pkg::stat_type stat;

   // sequencer: init sweep, idle, execute, walk, peek, clear sweep
   brfs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   // ring store, pointers, walk pipeline, result registers
   brfs_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_func        (req_func),
      .req_data_byte   (req_data_byte),
      .req_second_byte (req_second_byte),
      .req_count       (req_count),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_ok          (rsp_ok),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_found_pos   (rsp_found_pos),
      .rsp_used_count  (rsp_used_count),
      .rsp_free_count  (rsp_free_count),
      .rsp_last        (rsp_last)
   );

   // a taken request always makes the block busy on the next cycle
   a_take_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request taken but block not busy");

   // read results stream without gaps until the last one
   a_stream_contig : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=> rsp_valid)
      else $error("gap inside a read result stream");

   // only a granted read produces non-final results, all successful
   a_nonlast_ok : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (rsp_ok && busy))
      else $error("non-final result without success");

   // a refusal or a miss carries no byte and no position
   a_refuse_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_out_byte == '0 && rsp_found_pos == '0))
      else $error("refused result with payload");

endmodule
